// ===== hw/rtl/tha_pkg.sv =====
// ----------------------------------------------------------------------------
// tha_pkg
// Shared widths, fixed-point constants and types for the tanh approximation.
// ----------------------------------------------------------------------------
package tha_pkg;

    localparam int SAMPLE_W = 16;           // x in Q3.12
    localparam int OUT_W    = 16;           // tanh in Q1.14
    localparam int A_W      = 16;           // |x|, 0 .. 32768
    localparam int DEN1_W   = 16;           // a + 1.0 in Q.12
    localparam int T_W      = 14;           // t in Q0.14
    localparam int PROD_W   = 27;           // 0.37 * t before the shift
    localparam int M_W      = 15;           // m and n in Q.14
    localparam int D_W      = 18;           // n + a in Q.14
    localparam int Q_W      = 16;           // raw quotient

    localparam logic [DEN1_W-1:0] Q12_ONE = 16'd4096;
    localparam logic [M_W-1:0]    Q14_ONE = 15'd16384;
    localparam logic [12:0]       K_037   = 13'd6062;
    localparam logic [M_W-1:0]    K_070   = 15'd11469;

    typedef struct packed {
        logic space;                        // buffer can take a beat
        logic any;                          // buffer holds a beat
    } t_obuf_stat;

endpackage

// ===== hw/rtl/hyperbolic_tangent_approx.sv =====
// ----------------------------------------------------------------------------
// hyperbolic_tangent_approx
// Approximate tanh: x in Q3.12 to tanh(x) in Q1.14 via x / (n + |x|).
//
//   channel   direction  beat           handshake
//   sample    in         i_sample_in    i_sample_in_valid / o_sample_in_ready
//   tanh      out        o_tanh_out     o_tanh_out_valid  / i_tanh_out_ready
//
// one beat per cycle while the output buffer has space; 34 pipeline stages
// (input, 14-step divider, 3 divisor stages, 16-step divider) plus the
// output buffer; the two bit-per-stage dividers set the depth
// synchronous active-low reset empties the pipeline and the buffer
// the pipeline halts only when both buffer entries are full
// ----------------------------------------------------------------------------
module hyperbolic_tangent_approx (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic signed [tha_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                            i_sample_in_valid,
    output logic                            o_sample_in_ready,
    output logic signed [tha_pkg::OUT_W-1:0] o_tanh_out,
    output logic                            o_tanh_out_valid,
    input  logic                            i_tanh_out_ready
);

    logic                           w_en;
    tha_pkg::t_obuf_stat            w_stat;

    logic                           r_vld0;
    logic [tha_pkg::A_W-1:0]        r_a0;
    logic [tha_pkg::DEN1_W-1:0]     r_den0;
    logic                           r_neg0;
    logic [tha_pkg::A_W-1:0]        n_a0;

    logic                           w_d1_vld;
    logic [tha_pkg::T_W-1:0]        w_t;
    logic [tha_pkg::A_W:0]          w_d1_side;

    logic                           w_m_vld;
    logic [tha_pkg::D_W-1:0]        w_d;
    logic [tha_pkg::A_W-1:0]        w_m_a;
    logic                           w_m_neg;

    logic                           w_d2_vld;
    logic [tha_pkg::Q_W-1:0]        w_q;
    logic                           w_d2_neg;
    logic [tha_pkg::Q_W-1:0]        w_qs;
    logic [tha_pkg::OUT_W-1:0]      w_res;
    logic [tha_pkg::OUT_W-1:0]      w_buf_out;

    assign w_en              = w_stat.space;
    assign o_sample_in_ready = w_en;

    // magnitude, first divisor
    assign n_a0 = i_sample_in[tha_pkg::SAMPLE_W-1] ? (~i_sample_in + 1'b1) : i_sample_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (w_en) begin
            r_vld0 <= i_sample_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a0   <= n_a0;
            r_den0 <= n_a0 + tha_pkg::Q12_ONE;
            r_neg0 <= i_sample_in[tha_pkg::SAMPLE_W-1];
        end
    end

    // t = a / (a + 1)
    tha_divpipe #(
        .DW (tha_pkg::DEN1_W),
        .QW (tha_pkg::T_W),
        .SW (tha_pkg::A_W + 1)
    ) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vld0),
        .i_rem   (tha_pkg::DEN1_W'(r_a0)),
        .i_den   (r_den0),
        .i_side  ({r_neg0, r_a0}),
        .o_valid (w_d1_vld),
        .o_quo   (w_t),
        .o_side  (w_d1_side)
    );

    tha_mid u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d1_vld),
        .i_t     (w_t),
        .i_a     (w_d1_side[tha_pkg::A_W-1:0]),
        .i_neg   (w_d1_side[tha_pkg::A_W]),
        .o_valid (w_m_vld),
        .o_d     (w_d),
        .o_a     (w_m_a),
        .o_neg   (w_m_neg)
    );

    // |q| = a / (n + a)
    tha_divpipe #(
        .DW (tha_pkg::D_W),
        .QW (tha_pkg::Q_W),
        .SW (1)
    ) u_div_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_m_vld),
        .i_rem   (tha_pkg::D_W'(w_m_a)),
        .i_den   (w_d),
        .i_side  (w_m_neg),
        .o_valid (w_d2_vld),
        .o_quo   (w_q),
        .o_side  (w_d2_neg)
    );

    // saturate to one, restore sign
    assign w_qs  = (w_q > tha_pkg::Q_W'(tha_pkg::Q14_ONE)) ?
                   tha_pkg::Q_W'(tha_pkg::Q14_ONE) : w_q;
    assign w_res = w_d2_neg ? tha_pkg::OUT_W'(~w_qs + 1'b1) : tha_pkg::OUT_W'(w_qs);

    tha_obuf #(
        .W (tha_pkg::OUT_W)
    ) u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en && w_d2_vld),
        .i_data  (w_res),
        .i_pop   (o_tanh_out_valid && i_tanh_out_ready),
        .o_data  (w_buf_out),
        .o_stat  (w_stat)
    );

    assign o_tanh_out       = w_buf_out;
    assign o_tanh_out_valid = w_stat.any;

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tanh_out_valid |-> (o_tanh_out <= 16'sd16384 && o_tanh_out >= -16'sd16384))
        else $error("tanh result out of range");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_sample_in_ready |-> o_tanh_out_valid)
        else $error("input stalled with empty output buffer");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tanh_out_valid && !i_tanh_out_ready) |=> o_tanh_out_valid)
        else $error("pending result lost");

    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_d2_vld && !w_d2_neg) |-> !w_res[tha_pkg::OUT_W-1])
        else $error("positive sample gave negative result");

endmodule

// ===== hw/rtl/tha_divpipe.sv =====
// ----------------------------------------------------------------------------
// tha_divpipe
// Pipelined restoring divider, one quotient bit per stage. The dividend is
// the initial remainder shifted left by QW bits; it must be below the divisor.
// ----------------------------------------------------------------------------
module tha_divpipe #(
    parameter int DW = 16,
    parameter int QW = 14,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_vld  [QW];
    logic [DW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [SW-1:0] r_side [QW];
    logic [DW-1:0] n_rem  [QW];
    logic [QW-1:0] n_quo  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic          w_vld_in;
        logic [DW-1:0] w_rem_in;
        logic [DW-1:0] w_den_in;
        logic [QW-1:0] w_quo_in;
        logic [SW-1:0] w_side_in;
        logic [DW:0]   w_sh;
        logic [DW:0]   w_diff;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_vld_in  = i_valid;
            assign w_rem_in  = i_rem;
            assign w_den_in  = i_den;
            assign w_quo_in  = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_vld_in  = r_vld[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_den_in  = r_den[k-1];
            assign w_quo_in  = r_quo[k-1];
            assign w_side_in = r_side[k-1];
        end

        always_comb begin
            w_sh     = {w_rem_in, 1'b0};
            w_ge     = (w_sh >= {1'b0, w_den_in});
            w_diff   = w_sh - {1'b0, w_den_in};
            n_rem[k] = w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
            n_quo[k] = {w_quo_in[QW-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= w_den_in;
                r_quo[k]  <= n_quo[k];
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== hw/rtl/tha_mid.sv =====
// ----------------------------------------------------------------------------
// tha_mid
// Forms the second divisor n + a from t: one minus 0.37 t, floor at 0.7,
// subtract t with a floor at zero, add a. Three register stages.
// ----------------------------------------------------------------------------
module tha_mid (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [tha_pkg::T_W-1:0]     i_t,
    input  logic [tha_pkg::A_W-1:0]     i_a,
    input  logic                        i_neg,
    output logic                        o_valid,
    output logic [tha_pkg::D_W-1:0]     o_d,
    output logic [tha_pkg::A_W-1:0]     o_a,
    output logic                        o_neg
);

    // stage a: product
    logic                           r_vld_a;
    logic [tha_pkg::PROD_W-1:0]     r_prod;
    logic [tha_pkg::T_W-1:0]        r_t_a;
    logic [tha_pkg::A_W-1:0]        r_a_a;
    logic                           r_neg_a;
    logic [tha_pkg::PROD_W-1:0]     n_prod;

    // stage b: n
    logic                           r_vld_b;
    logic [tha_pkg::M_W-1:0]        r_n;
    logic [tha_pkg::A_W-1:0]        r_a_b;
    logic                           r_neg_b;
    logic [tha_pkg::M_W-1:0]        n_m;
    logic [tha_pkg::M_W-1:0]        n_mx;
    logic [tha_pkg::M_W-1:0]        n_n;

    // stage c: divisor
    logic                           r_vld_c;
    logic [tha_pkg::D_W-1:0]        r_d;
    logic [tha_pkg::A_W-1:0]        r_a_c;
    logic                           r_neg_c;
    logic [tha_pkg::D_W-1:0]        n_d;

    always_comb begin
        n_prod = tha_pkg::PROD_W'(tha_pkg::K_037) * tha_pkg::PROD_W'(i_t);
        n_m    = tha_pkg::Q14_ONE
               - tha_pkg::M_W'(r_prod[tha_pkg::PROD_W-1:tha_pkg::T_W]);
        n_mx   = (n_m < tha_pkg::K_070) ? tha_pkg::K_070 : n_m;
        n_n    = (n_mx > tha_pkg::M_W'(r_t_a)) ? (n_mx - tha_pkg::M_W'(r_t_a)) : '0;
        n_d    = tha_pkg::D_W'(r_n) + {r_a_b, 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_t_a   <= i_t;
            r_a_a   <= i_a;
            r_neg_a <= i_neg;
            r_n     <= n_n;
            r_a_b   <= r_a_a;
            r_neg_b <= r_neg_a;
            r_d     <= n_d;
            r_a_c   <= r_a_b;
            r_neg_c <= r_neg_b;
        end
    end

    assign o_valid = r_vld_c;
    assign o_d     = r_d;
    assign o_a     = r_a_c;
    assign o_neg   = r_neg_c;

endmodule

// ===== hw/rtl/tha_obuf.sv =====
// ----------------------------------------------------------------------------
// tha_obuf
// Two-entry output buffer. Keeps the pipeline moving while one result waits
// and absorbs the beat already in flight when the consumer stalls.
// ----------------------------------------------------------------------------
module tha_obuf #(
    parameter int W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [W-1:0]        i_data,
    input  logic                i_pop,
    output logic [W-1:0]        o_data,
    output tha_pkg::t_obuf_stat o_stat
);

    logic [W-1:0] r_mem [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;
    logic [1:0]   n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.space = (r_cnt != 2'd2);
    assign o_stat.any   = (r_cnt != 2'd0);

endmodule
